/* hw/rtl/i2a_pkg.sv */
// Shared types, constants and the digit-to-character map of the integer formatter.
`timescale 1ns / 1ps
`default_nettype none
package i2a_pkg;

	localparam int unsigned VAL_W  = 32;
	localparam int unsigned BIT_CW = 5;
	localparam int unsigned DIG_N  = 10;
	localparam int unsigned DIG_CW = 4;
	localparam int unsigned BCD_W  = DIG_N * 4;
	localparam int unsigned CHAR_W = 7;

	localparam logic [1:0] ACT_HEX  = 2'd0;
	localparam logic [1:0] ACT_UDEC = 2'd1;
	localparam logic [1:0] ACT_SDEC = 2'd2;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_A     = 7'h61;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

	typedef struct packed {
		logic              valid;
		logic [CHAR_W-1:0] ch;
		logic              last;
	} emit_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib);
		logic [CHAR_W-1:0] n;
		n = {3'b000, nib};
		if (nib < 4'd10) begin
			return CH_ZERO + n;
		end
		return CH_A + n - 7'd10;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/i2a_bin2bcd.sv */
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module i2a_bin2bcd
	import i2a_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [VAL_W-1:0] bin,
	output logic                  busy,
	output logic                  done,
	output logic [BCD_W-1:0]      bcd
);

	logic [VAL_W-1:0]  bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [BIT_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [BCD_W-1:0]  adj;

	always_comb begin
		for (int i = 0; i < DIG_N; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
			                                          : bcd_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == BIT_CW'(VAL_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == BIT_CW'(VAL_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[VAL_W-1]};
			bin_q <= {bin_q[VAL_W-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign bcd  = bcd_q;

endmodule
`default_nettype wire

/* hw/rtl/i2a_emit.sv */
// Character sequencer: strips leading zeros, then gives sign, padding and digits.
`timescale 1ns / 1ps
`default_nettype none
module i2a_emit
	import i2a_pkg::*;
#(
	parameter int unsigned W = 5
)
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [BCD_W-1:0] digits,
	input  wire logic             neg,
	input  wire logic [W-1:0]     width,
	input  wire logic             zero_pad,
	input  wire logic             adv,
	output emit_t                 out,
	output logic                  busy
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_STRIP = 5'b00010,
		ST_SIGN  = 5'b00100,
		ST_PAD   = 5'b01000,
		ST_DIGIT = 5'b10000
	} state_t;

	state_t            state_q;
	logic [BCD_W-1:0]  dig_q;
	logic [DIG_CW-1:0] ndig_q;
	logic [W-1:0]      padcnt_q;
	logic [W:0]        wext;
	logic [W:0]        nd_ext;
	logic [W-1:0]      pad_n;
	logic              top_zero;

	assign top_zero = (dig_q[BCD_W-1 -: 4] == 4'd0) && (ndig_q > DIG_CW'(1));
	assign wext     = (W+1)'(width);
	assign nd_ext   = (W+1)'(ndig_q);
	assign pad_n    = (wext > nd_ext) ? W'(wext - nd_ext) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ndig_q   <= '0;
			padcnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						ndig_q  <= DIG_CW'(DIG_N);
						state_q <= ST_STRIP;
					end
				end
				ST_STRIP: begin
					if (top_zero) begin
						ndig_q <= ndig_q - 1'b1;
					end else begin
						padcnt_q <= pad_n;
						if (neg) begin
							state_q <= ST_SIGN;
						end else if (pad_n != '0) begin
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_DIGIT;
						end
					end
				end
				ST_SIGN: begin
					if (adv) begin
						state_q <= (padcnt_q != '0) ? ST_PAD : ST_DIGIT;
					end
				end
				ST_PAD: begin
					if (adv) begin
						padcnt_q <= padcnt_q - 1'b1;
						if (padcnt_q == W'(1)) begin
							state_q <= ST_DIGIT;
						end
					end
				end
				ST_DIGIT: begin
					if (adv) begin
						ndig_q <= ndig_q - 1'b1;
						if (ndig_q == DIG_CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			dig_q <= digits;
		end else if ((state_q == ST_STRIP && top_zero) || (state_q == ST_DIGIT && adv)) begin
			dig_q <= {dig_q[BCD_W-5:0], 4'd0};
		end
	end

	always_comb begin
		out.valid = 1'b0;
		out.ch    = CH_SPACE;
		out.last  = 1'b0;
		case (state_q)
			ST_SIGN: begin
				out.valid = 1'b1;
				out.ch    = CH_MINUS;
			end
			ST_PAD: begin
				out.valid = 1'b1;
				out.ch    = zero_pad ? CH_ZERO : CH_SPACE;
			end
			ST_DIGIT: begin
				out.valid = 1'b1;
				out.ch    = digit_char(dig_q[BCD_W-1 -: 4]);
				out.last  = (ndig_q == DIG_CW'(1));
			end
			default: begin
				out.valid = 1'b0;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

/* hw/rtl/integer_to_ascii_formatter.sv */
// Top level of the integer to ASCII formatter: input capture, control and output register.
// Usage:
//   Slave channel s_*: one word per number, fields action, value, pad_width and
//   zero_pad. s_tready is high only while the block holds no number in work.
//   Master channel m_*: one ASCII character per word, m_tlast on the final one.
//   Hex: the value is loaded, then leading zeros are stripped one at a time (up
//   to 9), then one character per cycle while the receiver keeps up. Decimal:
//   the value first passes the bit-serial BCD converter (one value bit per
//   cycle) before stripping. A number gives n characters, n from 1 to 32.
//   The next number is taken once the final character sits in the output
//   register, so a stalled receiver overlaps with the next load.
//   Reset clears all control state; no output is valid after reset.
//   A stalled receiver holds the output word and freezes the sequencer's sign, pad and digit steps.
`timescale 1ns / 1ps
`default_nettype none
module integer_to_ascii_formatter
	import i2a_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 31
)
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// action[1:0], value[33:2], pad_width[38:34], zero_pad[39]
	input  wire logic [39:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// character[6:0], zero fill[7]
	output logic [7:0]       m_tdata,
	output logic             m_tlast
);

	localparam int unsigned CW = $clog2(MAX_WIDTH + 1);

	logic [1:0]       in_action;
	logic [VAL_W-1:0] in_value;
	logic [4:0]       in_pad_width;
	logic             in_zero_pad;
	logic             accept;
	logic             is_neg;
	logic             is_hex;
	logic [VAL_W-1:0] mag;
	logic [CW-1:0]    width_sat;

	logic [VAL_W-1:0] val_q;
	logic             neg_q;
	logic [CW-1:0]    width_q;
	logic             zero_pad_q;
	logic             hex_go_q;

	logic             conv_busy;
	logic             conv_done;
	logic [BCD_W-1:0] bcd;
	logic             emit_start;
	logic [BCD_W-1:0] emit_digits;
	emit_t            em;
	logic             emit_busy;
	logic             adv;

	logic              m_tvalid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	assign in_action    = s_tdata[1:0];
	assign in_value     = s_tdata[33:2];
	assign in_pad_width = s_tdata[38:34];
	assign in_zero_pad  = s_tdata[39];

	assign s_tready = !(conv_busy || conv_done || emit_busy || hex_go_q);
	assign accept   = s_tvalid && s_tready;
	assign is_hex   = (in_action == ACT_HEX);
	assign is_neg   = (in_action == ACT_SDEC) && in_value[VAL_W-1];
	assign mag      = is_neg ? (VAL_W'(0) - in_value) : in_value;
	assign width_sat = (32'(in_pad_width) > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH)
	                                                         : CW'(in_pad_width);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_go_q <= 1'b0;
		end else begin
			hex_go_q <= accept && is_hex;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q      <= in_value;
			neg_q      <= is_neg;
			width_q    <= width_sat;
			zero_pad_q <= in_zero_pad;
		end
	end

	i2a_bin2bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && !is_hex),
		.bin    (mag),
		.busy   (conv_busy),
		.done   (conv_done),
		.bcd    (bcd)
	);

	assign emit_start  = hex_go_q || conv_done;
	assign emit_digits = hex_go_q ? {{(BCD_W-VAL_W){1'b0}}, val_q} : bcd;
	assign adv         = !m_tvalid_q || m_tready;

	i2a_emit #(.W(CW)) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (emit_start),
		.digits   (emit_digits),
		.neg      (neg_q),
		.width    (width_q),
		.zero_pad (zero_pad_q),
		.adv      (adv),
		.out      (em),
		.busy     (emit_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= em.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			char_q <= em.ch;
			last_q <= em.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, char_q};
	assign m_tlast  = last_q;

`ifndef SYNTHESIS
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input taken while a number is in work");

	a_emit_after_conv: assert property (@(posedge clk) disable iff (!arst_n)
		em.valid |-> !conv_busy)
		else $error("characters emitted while converter busy");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit_start |-> !emit_busy)
		else $error("sequencer started while busy");

	a_hex_conv_excl: assert property (@(posedge clk) disable iff (!arst_n)
		hex_go_q |-> !(conv_busy || conv_done))
		else $error("hex and decimal paths active together");
`endif

endmodule
`default_nettype wire
